/* rtl/core/qec_pkg.sv */
// Shared types, constants and helpers for the quadrature encoder counter.
`default_nettype none
package qec_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int OUT_COUNT_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int DIV_WIDTH = 6;
  localparam int PRESCALE_WIDTH = 5;
  localparam int LEN_WIDTH = 4;
  localparam int RUN_WIDTH = 3;
  localparam int IN_TDATA_WIDTH = 8;
  localparam int OUT_TDATA_WIDTH = 24;

  localparam logic [DIV_WIDTH-1:0] DIV_MAX = 6'd32;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = 4'd8;
  localparam logic [15:0] RELOAD_RESET = 16'hFFFF;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COUNT_ENABLE   = 3'd0,
    REG_INVERT_A       = 3'd1,
    REG_AUTO_RELOAD    = 3'd2,
    REG_FILTER_DIVIDER = 3'd3,
    REG_FILTER_LENGTH  = 3'd4
  } qec_reg_t;

  // Filter results handed from the phase filters to the counter.
  typedef struct packed {
    logic edge_a;
    logic edge_b;
    logic level_a;
    logic level_b;
  } qec_edge_t;

  // Clamp divider to 1..32 and return divider minus one.
  function automatic logic [PRESCALE_WIDTH-1:0] div_last(input logic [DIV_WIDTH-1:0] d);
    logic [DIV_WIDTH-1:0] m;
    m = d;
    if (d == '0) begin
      m = 6'd1;
    end else if (d > DIV_MAX) begin
      m = DIV_MAX;
    end
    return PRESCALE_WIDTH'(m - 6'd1);
  endfunction

  // Clamp filter length to 1..8.
  function automatic logic [LEN_WIDTH-1:0] len_clamp(input logic [LEN_WIDTH-1:0] l);
    logic [LEN_WIDTH-1:0] m;
    m = l;
    if (l == '0) begin
      m = 4'd1;
    end else if (l > LEN_MAX) begin
      m = LEN_MAX;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/qec_filter.sv */
// Digital glitch filter for one encoder phase.
`default_nettype none
module qec_filter
  import qec_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire logic                 sample_en,
  input  wire logic                 raw,
  input  wire logic [LEN_WIDTH-1:0] need,
  output logic                      edge_det,
  output logic                      level_nxt
);

  logic [RUN_WIDTH-1:0] run_r, run_nxt;
  logic                 level_r;
  logic [LEN_WIDTH-1:0] run_inc;

  always_comb begin
    run_inc   = LEN_WIDTH'(run_r) + 4'd1;
    run_nxt   = run_r;
    level_nxt = level_r;
    edge_det  = 1'b0;
    if (sample_en) begin
      if (raw == level_r) begin
        run_nxt = '0;
      end else if (run_inc >= need) begin
        run_nxt   = '0;
        level_nxt = raw;
        edge_det  = 1'b1;
      end else begin
        run_nxt = run_inc[RUN_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= '0;
      level_r <= 1'b0;
    end else if (advance) begin
      run_r   <= run_nxt;
      level_r <= level_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/qec_counter.sv */
// Position counter with wrap at the reload value and direction flag.
`default_nettype none
module qec_counter
  import qec_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic                       clear,
  input  wire logic                       enable,
  input  wire logic [15:0]                auto_reload,
  input  wire qec_edge_t                  edges,
  output logic [OUT_COUNT_WIDTH-1:0]      count,
  output logic                            direction
);

  cnt_t count_r, count_nxt;
  logic down_r, down_nxt;
  cnt_t top;
  logic up;

  always_comb begin
    top       = COUNT_WIDTH'(auto_reload);
    up        = edges.edge_a ? (edges.level_a != edges.level_b)
                             : (edges.level_a == edges.level_b);
    count_nxt = count_r;
    down_nxt  = down_r;
    if (clear) begin
      count_nxt = '0;
    end else if (enable && (edges.edge_a != edges.edge_b)) begin
      if (up) begin
        down_nxt  = 1'b0;
        count_nxt = (count_r == top) ? '0 : count_r + 1'b1;
      end else begin
        down_nxt  = 1'b1;
        count_nxt = (count_r == '0) ? top : count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      down_r  <= 1'b0;
    end else if (advance) begin
      count_r <= count_nxt;
      down_r  <= down_nxt;
    end
  end

  assign count     = OUT_COUNT_WIDTH'(count_r);
  assign direction = down_r;

endmodule
`default_nettype wire

/* rtl/core/quadrature_encoder_counter.sv */
// Top level of the 4x quadrature encoder counter.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_tvalid/in_tready   | in_tdata: phase_a, phase_b, clear_count
//  out     | out_tvalid/out_tready | out_tdata: count[15:0], direction
//  cfg     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  One request per clock while the result is not stalled; a sample is held in the
//  input register, and its result is registered in the result register. The filter
//  and counter state update in the single compute stage. A stalled result holds; the
//  input register still takes one more request. Synchronous active-low reset clears
//  control state and loads configuration defaults; configuration is always ready.
`default_nettype none
module quadrature_encoder_counter
  import qec_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [IN_TDATA_WIDTH-1:0]  in_tdata,   // [0] phase_a, [1] phase_b, [2] clear_count
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [OUT_TDATA_WIDTH-1:0]      out_tdata,  // [15:0] count, [16] direction
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic                      enable_r;
  logic                      invert_a_r;
  logic [15:0]               reload_r;
  logic [DIV_WIDTH-1:0]      divider_r;
  logic [LEN_WIDTH-1:0]      length_r;

  logic                      s1_valid_r;
  logic                      s1_a_r, s1_b_r, s1_clr_r;
  logic                      out_valid_r;
  logic [PRESCALE_WIDTH-1:0] prescale_r, prescale_nxt;

  logic                      advance;
  logic                      in_accept;
  logic                      sample_en;
  logic [LEN_WIDTH-1:0]      need;
  logic                      filt_edge_a, filt_edge_b;
  logic                      filt_level_a, filt_level_b;
  qec_edge_t                 edges;
  logic [OUT_COUNT_WIDTH-1:0] count;
  logic                      direction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      invert_a_r <= 1'b0;
      reload_r   <= RELOAD_RESET;
      divider_r  <= DIV_MAX;
      length_r   <= LEN_MAX;
    end else if (cfg_valid) begin
      case (qec_reg_t'(cfg_index))
        REG_COUNT_ENABLE:   enable_r   <= cfg_data[0];
        REG_INVERT_A:       invert_a_r <= cfg_data[0];
        REG_AUTO_RELOAD:    reload_r   <= cfg_data;
        REG_FILTER_DIVIDER: divider_r  <= cfg_data[DIV_WIDTH-1:0];
        REG_FILTER_LENGTH:  length_r   <= cfg_data[LEN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_a_r   <= in_tdata[0];
      s1_b_r   <= in_tdata[1];
      s1_clr_r <= in_tdata[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    sample_en    = prescale_r >= div_last(divider_r);
    prescale_nxt = sample_en ? '0 : prescale_r + 1'b1;
    need         = len_clamp(length_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
    end else if (advance) begin
      prescale_r <= prescale_nxt;
    end
  end

  qec_filter u_filter_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .sample_en (sample_en),
    .raw       (s1_a_r ^ invert_a_r),
    .need      (need),
    .edge_det  (filt_edge_a),
    .level_nxt (filt_level_a)
  );

  qec_filter u_filter_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .sample_en (sample_en),
    .raw       (s1_b_r),
    .need      (need),
    .edge_det  (filt_edge_b),
    .level_nxt (filt_level_b)
  );

  always_comb begin
    edges.edge_a  = filt_edge_a;
    edges.edge_b  = filt_edge_b;
    edges.level_a = filt_level_a;
    edges.level_b = filt_level_b;
  end

  qec_counter u_counter (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .clear       (s1_clr_r),
    .enable      (enable_r),
    .auto_reload (reload_r),
    .edges       (edges),
    .count       (count),
    .direction   (direction)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, direction, count};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are full");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_clr_r) |=> (out_tdata[15:0] == '0))
    else $error("clear request did not zero the count");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(out_tdata))
    else $error("result changed without a processed request");

  a_edge_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
    (edges.edge_a || edges.edge_b) |-> sample_en)
    else $error("filter edge outside a sample tick");

endmodule
`default_nettype wire
